// ===== design/lfd_pkg.sv =====
// Shared types, register codes and constants of the flanger delay block.
package lfd_pkg;

	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;
	localparam int DIST_W     = 11;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PHASE_STEP    = 8'd0,
		CFG_DELAY_SPAN    = 8'd1,
		CFG_FEEDBACK_GAIN = 8'd2,
		CFG_WET_MIX       = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic        [23:0] lfo_phase_step;
		logic        [10:0] delay_span;
		logic signed [15:0] feedback_gain;
		logic        [15:0] wet_mix;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [DIST_W-1:0] offset;
	} lfd_dist_t;

	localparam logic        [23:0] RST_PHASE_STEP    = 24'd22370;
	localparam logic        [10:0] RST_DELAY_SPAN    = 11'd240;
	localparam logic signed [15:0] RST_FEEDBACK_GAIN = 16'sd22938;
	localparam logic        [15:0] RST_WET_MIX       = 16'd16384;

	localparam logic [15:0] WET_FULL = 16'd32768;

	// Sine table generation, Q30 series
	localparam longint Q30_ONE = 64'sd1073741824;
	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint TAYLOR_DIV [6] = '{64'sd6, 64'sd20, 64'sd42, 64'sd72, 64'sd110, 64'sd156};

endpackage

// ===== design/lfd_if.sv =====
// Channel interfaces: sample input, sample output and register write.
interface lfd_in_if #(parameter int SampleBits = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [SampleBits-1:0] sample_in;
	modport source(output valid, output sample_in, input ready);
	modport sink(input valid, input sample_in, output ready);
endinterface

interface lfd_out_if #(parameter int SampleBits = 16) ();
	logic                         valid;
	logic                         ready;
	logic signed [SampleBits-1:0] sample_out;
	modport source(output valid, output sample_out, input ready);
	modport sink(input valid, input sample_out, output ready);
endinterface

interface lfd_cfg_if import lfd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// ===== design/lfo_flanger_delay.sv =====
// Flanger: LFO-modulated delay line with feedback, top level.
// One sample is in flight at a time: a transfer on din is taken, the LFO phase steps,
// the sine table and span give the delay, the delay RAM is read, the feedback sum is
// written back and the mix is loaded into the output register. The steps are the phase
// step; table lookup, delay scaling and wrap; the RAM read; the multiplies; and the
// write-back with output load. A new sample is taken only after the previous one has been
// written back; the write-back waits while the previous result still sits unread in the
// output register. The RAM needs no clearing after reset: entries not yet written since
// reset read as zero.
module lfo_flanger_delay import lfd_pkg::*; #(
	parameter int DELAY_DEPTH     = 2048,
	parameter int SINE_TABLE_SIZE = 256,
	parameter int SAMPLE_BITS     = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	lfd_cfg_if.sink    cfg,
	lfd_in_if.sink     din,
	lfd_out_if.source  dout
);

	cfg_t      regs;
	lfd_dist_t tap;
	logic      busy_q;
	logic      start;
	logic      done;

	assign din.ready = !busy_q;
	assign start     = din.valid && din.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	lfd_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lfd_lfo #(
		.DELAY_DEPTH     (DELAY_DEPTH),
		.SINE_TABLE_SIZE (SINE_TABLE_SIZE)
	) u_lfo (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.regs   (regs),
		.tap    (tap)
	);

	lfd_line #(
		.DELAY_DEPTH (DELAY_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_line (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.dry_in (din.sample_in),
		.tap    (tap),
		.regs   (regs),
		.dout   (dout),
		.done   (done)
	);

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !din.ready)
		else $error("input taken while a sample is in flight");

endmodule

// ===== design/lfd_regs.sv =====
// Configuration register file with write decoder.
module lfd_regs import lfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	lfd_cfg_if.sink cfg,
	output cfg_t   regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.lfo_phase_step <= RST_PHASE_STEP;
			regs_q.delay_span     <= RST_DELAY_SPAN;
			regs_q.feedback_gain  <= RST_FEEDBACK_GAIN;
			regs_q.wet_mix        <= RST_WET_MIX;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PHASE_STEP:    regs_q.lfo_phase_step <= cfg.data[23:0];
				CFG_DELAY_SPAN:    regs_q.delay_span     <= cfg.data[10:0];
				CFG_FEEDBACK_GAIN: regs_q.feedback_gain  <= signed'(cfg.data[15:0]);
				CFG_WET_MIX:       regs_q.wet_mix        <= cfg.data[15:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/lfd_lfo.sv =====
// Sine LFO: phase accumulator, sine table and modulated delay distance.
module lfd_lfo import lfd_pkg::*; #(
	parameter int DELAY_DEPTH     = 2048,
	parameter int SINE_TABLE_SIZE = 256
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  cfg_t      regs,
	output lfd_dist_t tap
);

	localparam int IdxW = $clog2(SINE_TABLE_SIZE);
	localparam int PhW  = 32 + IdxW;

	typedef logic signed [15:0] rom_t [SINE_TABLE_SIZE];

	function automatic logic signed [15:0] quarter_sine(input longint r);
		longint x;
		longint x2;
		longint term;
		longint sum;
		x    = (PI_Q30 * r) / (2 * SINE_TABLE_SIZE);
		x2   = (x * x) / Q30_ONE;
		term = x;
		sum  = x;
		for (int i = 0; i < 6; i++) begin
			term = (-(term * x2)) / Q30_ONE;
			term = term / TAYLOR_DIV[i];
			sum  = sum + term;
		end
		if (sum < 0) sum = 0;
		if (sum > Q30_ONE) sum = Q30_ONE;
		return 16'((sum * 32767 + Q30_ONE / 2) / Q30_ONE);
	endfunction

	function automatic rom_t build_rom();
		rom_t   rom;
		longint a;
		longint q;
		longint r;
		for (int k = 0; k < SINE_TABLE_SIZE; k++) begin
			a = 4 * k;
			q = a / SINE_TABLE_SIZE;
			r = a - q * SINE_TABLE_SIZE;
			case (q)
				0:       rom[k] = quarter_sine(r);
				1:       rom[k] = quarter_sine(SINE_TABLE_SIZE - r);
				2:       rom[k] = -quarter_sine(r);
				default: rom[k] = -quarter_sine(SINE_TABLE_SIZE - r);
			endcase
		end
		return rom;
	endfunction

	// distance modulo depth by restoring subtraction, distance below 2048
	function automatic logic [DIST_W-1:0] mod_depth(input logic [DIST_W-1:0] d);
		logic [DIST_W-1:0] v;
		logic [31:0]       lim;
		v = d;
		for (int k = 7; k >= 0; k--) begin
			lim = 32'(DELAY_DEPTH) << k;
			if (32'(v) >= lim) v = v - DIST_W'(lim);
		end
		return v;
	endfunction

	localparam rom_t SineRom = build_rom();

	logic [31:0]        phase_q;
	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [IdxW-1:0]    idx_s2;
	logic signed [15:0] lfo_s3;
	logic [DIST_W-1:0]  d_s4;
	logic [DIST_W-1:0]  dist_s5;
	logic [PhW-1:0]     idx_prod;
	logic [15:0]        lfo_offs;
	logic [26:0]        span_prod;

	assign idx_prod  = PhW'(phase_q) * PhW'(SINE_TABLE_SIZE);
	assign lfo_offs  = {~lfo_s3[15], lfo_s3[14:0]};
	assign span_prod = 27'(regs.delay_span) * 27'(lfo_offs);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
		end else begin
			if (start) phase_q <= phase_q + 32'(regs.lfo_phase_step);
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) idx_s2 <= idx_prod[PhW-1 -: IdxW];
		if (v_s2) lfo_s3 <= SineRom[idx_s2];
		if (v_s3) d_s4 <= span_prod[26:16];
		if (v_s4) dist_s5 <= mod_depth(d_s4);
	end

	assign tap.valid  = v_s5;
	assign tap.offset = dist_s5;

	a_dist_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		tap.valid |-> (32'(tap.offset) < 32'(DELAY_DEPTH)))
		else $error("delay distance not reduced below depth");

endmodule

// ===== design/lfd_line.sv =====
// Delay line RAM with feedback write-back, dry/wet mix and output register.
module lfd_line import lfd_pkg::*; #(
	parameter int DELAY_DEPTH = 2048,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_BITS-1:0] dry_in,
	input  lfd_dist_t                     tap,
	input  cfg_t                          regs,
	lfd_out_if.source                     dout,
	output logic                          done
);

	localparam int AddrW = $clog2(DELAY_DEPTH);
	localparam int CmpW  = ((AddrW > DIST_W) ? AddrW : DIST_W) + 1;
	localparam int FbW   = SAMPLE_BITS + 17;
	localparam int MixW  = SAMPLE_BITS + 18;

	function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [MixW-1:0] v);
		logic signed [MixW-1:0] hi;
		logic signed [MixW-1:0] lo;
		hi = (MixW'(1) <<< (SAMPLE_BITS - 1)) - MixW'(1);
		lo = -hi - MixW'(1);
		if (v > hi) return SAMPLE_BITS'(hi);
		if (v < lo) return SAMPLE_BITS'(lo);
		return SAMPLE_BITS'(v);
	endfunction

	logic signed [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

	logic [AddrW-1:0]              wp_q;
	logic                          full_q;
	logic signed [SAMPLE_BITS-1:0] dry_q;
	logic                          v_s1;
	logic                          rdok_s1;
	logic signed [SAMPLE_BITS-1:0] rdata_s1;
	logic                          pend_s2;
	logic signed [FbW-1:0]         fb_prod_s2;
	logic signed [FbW-1:0]         dry_prod_s2;
	logic signed [FbW-1:0]         wet_prod_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic [CmpW-1:0]               wp_x, d_x, rd_x;
	logic [AddrW-1:0]              rd;
	logic signed [SAMPLE_BITS-1:0] delayed;
	logic [15:0]                   wet_c;
	logic signed [16:0]            wet_s, inv_s;
	logic signed [FbW-1:0]         fb_r;
	logic signed [MixW-1:0]        mix_r;
	logic signed [SAMPLE_BITS-1:0] stored;
	logic signed [SAMPLE_BITS-1:0] mix;
	logic                          fire;

	// read address, distance zero lands on the oldest entry
	assign wp_x = CmpW'(wp_q);
	assign d_x  = CmpW'(tap.offset);
	assign rd_x = (wp_x >= d_x) ? (wp_x - d_x) : (wp_x + CmpW'(DELAY_DEPTH) - d_x);
	assign rd   = rd_x[AddrW-1:0];

	assign delayed = rdok_s1 ? rdata_s1 : '0;
	assign wet_c   = (regs.wet_mix > WET_FULL) ? WET_FULL : regs.wet_mix;
	assign wet_s   = signed'({1'b0, wet_c});
	assign inv_s   = signed'(17'({1'b0, WET_FULL}) - 17'({1'b0, wet_c}));

	assign fb_r   = (fb_prod_s2 + FbW'(16384)) >>> 15;
	assign stored = sat(MixW'(dry_q) + MixW'(fb_r));
	assign mix_r  = (MixW'(dry_prod_s2) + MixW'(wet_prod_s2) + MixW'(16384)) >>> 15;
	assign mix    = sat(mix_r);

	assign fire = pend_s2 && (!out_valid_q || dout.ready);
	assign done = fire;

	assign dout.valid      = out_valid_q;
	assign dout.sample_out = out_sample_q;

	always_ff @(posedge clk) begin
		if (tap.valid) rdata_s1 <= mem[rd];
	end

	always_ff @(posedge clk) begin
		if (fire) mem[wp_q] <= stored;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q        <= '0;
			full_q      <= 1'b0;
			v_s1        <= 1'b0;
			pend_s2     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= tap.valid;
			if (v_s1) begin
				pend_s2 <= 1'b1;
			end else if (fire) begin
				pend_s2 <= 1'b0;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (wp_q == AddrW'(DELAY_DEPTH - 1)) begin
					wp_q   <= '0;
					full_q <= 1'b1;
				end else begin
					wp_q <= wp_q + AddrW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) dry_q <= dry_in;
		if (tap.valid) rdok_s1 <= full_q || (rd < wp_q);
		if (v_s1) begin
			fb_prod_s2  <= FbW'(regs.feedback_gain) * FbW'(delayed);
			dry_prod_s2 <= FbW'(dry_q) * FbW'(inv_s);
			wet_prod_s2 <= FbW'(delayed) * FbW'(wet_s);
		end
		if (fire) out_sample_q <= mix;
	end

	a_fire_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("write-back without output transfer pending");

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> !pend_s2)
		else $error("second item reached the mix stage while one is pending");

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the flanger delay: predicted mixes under random traffic and stalls.
module testbench import lfd_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     CLK_PERIOD  = 12;
	localparam int     LINE_LEN    = 2048;
	localparam int     LUT_LEN     = 256;
	localparam int     QUIET_LIMIT = 2000;
	localparam longint Q30         = 64'sd1073741824;
	localparam longint PI30        = 64'sd3373259426;

	class flanged_sample_check;
		logic signed [15:0] echo_line [LINE_LEN];
		logic signed [15:0] sine_lut [LUT_LEN];
		logic        [10:0] head;
		logic        [31:0] lfo_acc;
		logic        [23:0] rate;
		logic        [10:0] span;
		logic signed [15:0] fb;
		logic        [15:0] wet;
		logic signed [15:0] flanged_due [$];
		int                 faults;

		function new();
			longint a, q, r, k;
			foreach (echo_line[i]) echo_line[i] = '0;
			for (k = 0; k < LUT_LEN; k++) begin
				a = 4 * k;
				q = a / LUT_LEN;
				r = a - q * LUT_LEN;
				case (q)
					0: sine_lut[k] = 16'(quarter_wave(r));
					1: sine_lut[k] = 16'(quarter_wave(LUT_LEN - r));
					2: sine_lut[k] = 16'(-quarter_wave(r));
					default: sine_lut[k] = 16'(-quarter_wave(LUT_LEN - r));
				endcase
			end
			head    = '0;
			lfo_acc = '0;
			rate    = RST_PHASE_STEP;
			span    = RST_DELAY_SPAN;
			fb      = RST_FEEDBACK_GAIN;
			wet     = RST_WET_MIX;
			faults  = 0;
		endfunction

		// 32767 * sin(pi/2 * r / LUT_LEN), Q30 Taylor series, rounded
		function longint quarter_wave(longint r);
			longint x, x2, term, acc;
			int i;
			x    = (PI30 * r) / (2 * LUT_LEN);
			x2   = (x * x) / Q30;
			term = x;
			acc  = x;
			for (i = 1; i <= 6; i++) begin
				term = -(term * x2) / Q30;
				term = term / longint'((2 * i) * (2 * i + 1));
				acc += term;
			end
			if (acc < 0) acc = 0;
			if (acc > Q30) acc = Q30;
			return (acc * 32767 + Q30 / 2) / Q30;
		endfunction

		function logic signed [15:0] clip(longint v);
			if (v > 32767) return 16'sh7FFF;
			if (v < -32768) return 16'sh8000;
			return 16'(v);
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_PHASE_STEP:    rate = data[23:0];
				CFG_DELAY_SPAN:    span = data[10:0];
				CFG_FEEDBACK_GAIN: fb   = data[15:0];
				CFG_WET_MIX:       wet  = data[15:0];
				default: ;
			endcase
		endfunction

		function void take_sample(logic signed [15:0] dry);
			longint lfo, lag, delayed, mix, w;
			logic [10:0] rd;
			lfo_acc = lfo_acc + {8'h00, rate};
			lfo     = sine_lut[lfo_acc[31:24]];
			lag     = (longint'(span) * (32768 + lfo)) >>> 16;
			rd      = head - 11'(lag % LINE_LEN);
			delayed = echo_line[rd];
			echo_line[head] = clip(longint'(dry) + ((longint'(fb) * delayed + 16384) >>> 15));
			head = head + 11'd1;
			w    = (wet > WET_FULL) ? longint'(WET_FULL) : longint'(wet);
			mix  = longint'(dry) * (32768 - w) + delayed * w;
			flanged_due.insert(flanged_due.size(), clip((mix + 16384) >>> 15));
		endfunction

		function void match_output(logic signed [15:0] got);
			logic signed [15:0] want;
			if (flanged_due.size() == 0) begin
				$error("sample_out: no transfer expected, expected none actual %0d", got);
				faults++;
				return;
			end
			want = flanged_due.pop_front();
			if (got !== want) begin
				$error("sample_out: expected %0d actual %0d", want, got);
				faults++;
			end
		endfunction

		function int outstanding();
			return flanged_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm;
	int   quiet_cycles = 0;
	flanged_sample_check book;

	lfd_cfg_if cfg_ch();
	lfd_in_if  #(.SampleBits(16)) din_ch();
	lfd_out_if #(.SampleBits(16)) dout_ch();

	lfo_flanger_delay #(
		.DELAY_DEPTH(LINE_LEN),
		.SINE_TABLE_SIZE(LUT_LEN),
		.SAMPLE_BITS(16)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.din(din_ch),
		.dout(dout_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		book.set_register(idx, data);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] step_w, span_w, fb_w, wet_w);
		write_reg(CFG_PHASE_STEP, step_w);
		write_reg(CFG_DELAY_SPAN, span_w);
		write_reg(CFG_FEEDBACK_GAIN, fb_w);
		write_reg(CFG_WET_MIX, wet_w);
		if ($urandom_range(0, 1) == 0)
			write_reg(8'($urandom_range(CFG_WET_MIX + 1, (1 << CFG_IDX_W) - 1)),
				24'($urandom()));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic play_sample(input logic signed [15:0] s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			din_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		din_ch.valid     <= 1'b1;
		din_ch.sample_in <= s;
		do @(posedge clk); while (din_ch.ready !== 1'b1);
		book.take_sample(s);
	endtask

	task automatic settle();
		din_ch.valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_sample();
		logic signed [15:0] v;
		v = 16'($urandom());
		case ($urandom_range(0, 7))
			0: v = 16'sh7FFF;
			1: v = 16'sh8000;
			2: v = v >>> 8;
			default: ;
		endcase
		return v;
	endfunction

	// sink side: random back-pressure bursts, none once calm
	initial begin
		dout_ch.ready <= 1'b0;
		@(posedge clk iff arst_n === 1'b1);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				dout_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			dout_ch.ready <= 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1)
			book.match_output(dout_ch.sample_out);
	end

	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (cfg_ch.valid && cfg_ch.ready) || (din_ch.valid && din_ch.ready)
			|| (dout_ch.valid && dout_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int p;
		book = new();
		calm = 1'b0;
		arst_n           <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.index     <= '0;
		cfg_ch.data      <= '0;
		din_ch.valid     <= 1'b0;
		din_ch.sample_in <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings, full-scale and alternating bit patterns
		play_sample(16'sh7FFF);
		play_sample(16'sh8000);
		play_sample(16'sh0000);
		play_sample(16'shFFFF);
		play_sample(16'sh5555);
		play_sample(16'shAAAA);
		settle();

		// zero delay, feedback of minus one via masked word, wet above one, unknown index
		write_reg(8'(CFG_WET_MIX + 1), 24'hFFFFFF);
		program_regs(24'hFFFFFF, 24'h000000, 24'hFF8000, 24'h00FFFF);
		play_sample(16'sh7FFF);
		play_sample(16'sh7FFF);
		play_sample(16'sh8000);
		play_sample(16'sh0001);
		settle();

		// longest span, frozen LFO, strongest positive feedback, fully dry
		program_regs(24'h000000, 24'hFFF7FF, 24'h007FFF, 24'h000000);
		play_sample(16'sh7FFF);
		play_sample(16'sh8000);
		play_sample(16'shFFFF);
		play_sample(16'sh0000);
		settle();

		// one-sample span: delay truncated to zero at every LFO value, fully wet
		program_regs(24'h800000, 24'h000001, 24'hFF8001, 24'h008000);
		play_sample(16'sh7FFF);
		play_sample(16'sh4000);
		play_sample(16'shC000);
		play_sample(16'sh8000);
		play_sample(16'sh1234);
		play_sample(16'shEDCC);
		settle();

		for (p = 0; p < 6; p++) begin
			calm = (p == 5);
			case (p)
				0: program_regs(24'hFFFFFF, 24'd2047, 24'h007FFF, 24'h008000);
				1: program_regs(24'($urandom()), 24'($urandom()), 24'($urandom()),
					24'($urandom()));
				2: program_regs(24'd0, 24'd0, 24'h008001, 24'd0);
				3: program_regs(24'($urandom_range(0, 24'hFFFF)), 24'($urandom_range(1, 64)),
					24'h008000, 24'($urandom()));
				4: program_regs(24'($urandom()), 24'($urandom_range(1024, 2047)),
					24'($urandom()), 24'($urandom_range(0, 32768)));
				default: program_regs(24'($urandom_range(1 << 20, 24'hFFFFFF)),
					24'($urandom()), 24'($urandom()), 24'($urandom_range(0, 32768)));
			endcase
			repeat (222) play_sample(pick_sample());
			settle();
		end

		repeat (16) @(posedge clk);
		if (book.faults == 0 && book.outstanding() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
